// ----- hdl/iem_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package iem_pkg;

  // Command kinds carried by an input item.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_PROBE = 2'd3;

  // Completion status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NACK     = 2'd1;
  localparam logic [1:0] STATUS_POLL_TMO = 2'd2;
  localparam logic [1:0] STATUS_BAD_CNT  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_SELECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BYTES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BITS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_WAIT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_GAP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_TRIES     = 3'd6;

  // Register reset values.
  localparam logic [7:0]  RST_DEVICE_SELECT  = 8'hA0;
  localparam logic [1:0]  RST_ADDR_BYTES     = 2'd1;
  localparam logic        RST_HIGH_BITS      = 1'b0;
  localparam logic [7:0]  RST_LONG_HOLD      = 8'd4;
  localparam logic [15:0] RST_ACK_WAIT_LIMIT = 16'h1000;
  localparam logic [15:0] RST_POLL_GAP       = 16'd500;
  localparam logic [7:0]  RST_POLL_TRIES     = 8'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sda_in;
    logic [15:0] mem_addr;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Configuration write bundle.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ----- hdl/iem_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module iem_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update for each transfer.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/iem_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
module iem_engine import iem_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_wr_t   cfg,
  input  wire logic      item_avail,
  input  wire in_item_t  item,
  output logic           item_take,
  input  wire logic      res_full,
  output logic           res_push,
  output out_item_t      res
);

  typedef enum logic [21:0] {
    PH_IDLE = 22'h000001, PH_ST_A = 22'h000002, PH_ST_B = 22'h000004,
    PH_ST_C = 22'h000008, PH_ST_D = 22'h000010, PH_WB_A = 22'h000020,
    PH_WB_B = 22'h000040, PH_WB_C = 22'h000080, PH_AK_A = 22'h000100,
    PH_AK_B = 22'h000200, PH_AK_C = 22'h000400, PH_RB_A = 22'h000800,
    PH_RB_B = 22'h001000, PH_RA_A = 22'h002000, PH_RA_B = 22'h004000,
    PH_RA_C = 22'h008000, PH_REQ  = 22'h010000, PH_LOAD = 22'h020000,
    PH_SP_A = 22'h040000, PH_SP_B = 22'h080000, PH_SP_C = 22'h100000,
    PH_GAP  = 22'h200000
  } phase_t;

  typedef enum logic [10:0] {
    SG_SELW = 11'h001, SG_AHI = 11'h002, SG_ALO = 11'h004, SG_SELR = 11'h008,
    SG_DATA = 11'h010, SG_POLL = 11'h020, SG_POLL_FIRST = 11'h040,
    SG_POLL_RETRY = 11'h080, SG_END_OK = 11'h100, SG_END_NACK = 11'h200,
    SG_END_TMO = 11'h400
  } stage_t;

  // Configuration registers.
  logic [7:0]  dev_sel_r;
  logic [1:0]  addr_bytes_r;
  logic        high_bits_r;
  logic [7:0]  long_hold_r;
  logic [15:0] ack_limit_r;
  logic [15:0] poll_gap_r;
  logic [7:0]  poll_tries_r;

  // Engine state.
  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [1:0]  op_kind_r, op_kind_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] ack_cnt_r, ack_cnt_nxt;
  logic [7:0]  poll_cnt_r, poll_cnt_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;

  logic [15:0] tick_inc;
  logic        hold_long, hold_gap;
  logic [7:0]  sel_base, shift_in;
  logic [7:0]  poll_inc;
  logic [15:0] left_dec;

  assign item_take = item_avail && !res_full;
  assign res_push  = item_take;

  assign tick_inc  = tick_r + 16'd1;
  assign hold_long = tick_inc >= {8'd0, long_hold_r};
  assign hold_gap  = tick_inc >= poll_gap_r;
  // Address bits 10..8 land in select bits 3..1 when enabled.
  assign sel_base  = (dev_sel_r & 8'hFE) | (high_bits_r ? (addr_r[14:7] & 8'h0E) : 8'h00);
  assign shift_in  = {shift_r[6:0], item.sda_in};
  assign poll_inc  = poll_cnt_r + 8'd1;
  assign left_dec  = (left_r != '0) ? left_r - 16'd1 : left_r;

  // One bus tick: next state and the result item of this transfer.
  always_comb begin
    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    op_kind_nxt  = op_kind_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    tick_nxt     = tick_r;
    ack_cnt_nxt  = ack_cnt_r;
    poll_cnt_nxt = poll_cnt_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    res          = '0;

    case (phase_r)
      PH_IDLE: begin
        if (item.kind == KIND_READ && item.byte_count == '0) begin
          res.done_res = 1'b1;
          res.status   = STATUS_BAD_CNT;
        end else if (item.kind != KIND_TICK) begin
          op_kind_nxt  = item.kind;
          addr_nxt     = item.mem_addr;
          left_nxt     = item.byte_count;
          poll_cnt_nxt = '0;
          stage_nxt    = SG_SELW;
          phase_nxt    = PH_ST_A;
          tick_nxt     = '0;
        end
      end
      PH_ST_A: begin
        sda_nxt = 1'b1; phase_nxt = PH_ST_B; tick_nxt = '0;
      end
      PH_ST_B: begin
        scl_nxt = 1'b1; tick_nxt = tick_inc;
        if (hold_long) begin
          phase_nxt = PH_ST_C; tick_nxt = '0;
        end
      end
      PH_ST_C: begin
        sda_nxt = 1'b0; tick_nxt = tick_inc;
        if (hold_long) begin
          phase_nxt = PH_ST_D; tick_nxt = '0;
        end
      end
      PH_ST_D: begin
        scl_nxt     = 1'b0;
        shift_nxt   = sel_base | {7'd0, stage_r == SG_SELR};
        bit_idx_nxt = 4'd7;
        phase_nxt   = PH_WB_A;
        tick_nxt    = '0;
      end
      PH_WB_A: begin
        sda_nxt = shift_r[bit_idx_r[2:0]]; phase_nxt = PH_WB_B; tick_nxt = '0;
      end
      PH_LOAD: begin
        shift_nxt   = item.write_byte;
        bit_idx_nxt = 4'd7;
        sda_nxt     = item.write_byte[7];
        phase_nxt   = PH_WB_B;
        tick_nxt    = '0;
      end
      PH_WB_B: begin
        scl_nxt = 1'b1; phase_nxt = PH_WB_C; tick_nxt = '0;
      end
      PH_WB_C: begin
        scl_nxt  = 1'b0;
        tick_nxt = '0;
        if (bit_idx_r == '0) begin
          phase_nxt = PH_AK_A;
        end else begin
          bit_idx_nxt = bit_idx_r - 4'd1;
          phase_nxt   = PH_WB_A;
        end
      end
      PH_AK_A: begin
        sda_nxt = 1'b1; phase_nxt = PH_AK_B; tick_nxt = '0;
      end
      PH_AK_B: begin
        scl_nxt = 1'b1; ack_cnt_nxt = '0; phase_nxt = PH_AK_C; tick_nxt = '0;
      end
      PH_AK_C: begin
        if (!item.sda_in) begin
          // Acknowledge seen: move on to the next step of the sequence.
          scl_nxt  = 1'b0;
          tick_nxt = '0;
          case (stage_r)
            SG_SELW: begin
              if (op_kind_r == KIND_PROBE) begin
                stage_nxt = SG_END_OK; phase_nxt = PH_SP_A;
              end else if (addr_bytes_r == 2'd1) begin
                stage_nxt = SG_ALO; shift_nxt = addr_r[7:0];
                bit_idx_nxt = 4'd7; phase_nxt = PH_WB_A;
              end else begin
                stage_nxt = SG_AHI; shift_nxt = addr_r[15:8];
                bit_idx_nxt = 4'd7; phase_nxt = PH_WB_A;
              end
            end
            SG_AHI: begin
              stage_nxt = SG_ALO; shift_nxt = addr_r[7:0];
              bit_idx_nxt = 4'd7; phase_nxt = PH_WB_A;
            end
            SG_ALO: begin
              if (op_kind_r == KIND_READ) begin
                stage_nxt = SG_SELR; phase_nxt = PH_ST_A;
              end else if (left_r == '0) begin
                stage_nxt = SG_POLL_FIRST; phase_nxt = PH_SP_A;
              end else begin
                stage_nxt = SG_DATA; phase_nxt = PH_REQ;
              end
            end
            SG_SELR: begin
              stage_nxt = SG_DATA; bit_idx_nxt = 4'd7;
              shift_nxt = '0; phase_nxt = PH_RB_A;
            end
            SG_DATA: begin
              left_nxt = left_dec;
              addr_nxt = addr_r + 16'd1;
              if (left_dec == '0) begin
                stage_nxt = SG_POLL_FIRST; phase_nxt = PH_SP_A;
              end else begin
                stage_nxt = SG_DATA; phase_nxt = PH_REQ;
              end
            end
            SG_POLL: begin
              stage_nxt = SG_END_OK; phase_nxt = PH_SP_A;
            end
            default: begin
              stage_nxt = SG_END_NACK; phase_nxt = PH_SP_A;
            end
          endcase
        end else if (ack_cnt_r >= ack_limit_r) begin
          // No acknowledge within the limit.
          tick_nxt  = '0;
          phase_nxt = PH_SP_A;
          if (stage_r == SG_POLL) begin
            poll_cnt_nxt = poll_inc;
            stage_nxt    = (poll_inc >= poll_tries_r) ? SG_END_TMO : SG_POLL_RETRY;
          end else begin
            stage_nxt = SG_END_NACK;
          end
        end else begin
          ack_cnt_nxt = ack_cnt_r + 16'd1;
        end
      end
      PH_RB_A: begin
        sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_RB_B; tick_nxt = '0;
      end
      PH_RB_B: begin
        shift_nxt = shift_in;
        scl_nxt   = 1'b0;
        tick_nxt  = '0;
        if (bit_idx_r == '0) begin
          res.read_byte  = shift_in;
          res.read_valid = 1'b1;
          res.read_last  = (left_r <= 16'd1);
          phase_nxt      = PH_RA_A;
        end else begin
          bit_idx_nxt = bit_idx_r - 4'd1;
          phase_nxt   = PH_RB_A;
        end
      end
      PH_RA_A: begin
        sda_nxt = (left_r <= 16'd1); phase_nxt = PH_RA_B; tick_nxt = '0;
      end
      PH_RA_B: begin
        scl_nxt = 1'b1; phase_nxt = PH_RA_C; tick_nxt = '0;
      end
      PH_RA_C: begin
        scl_nxt  = 1'b0;
        sda_nxt  = 1'b1;
        left_nxt = left_dec;
        tick_nxt = '0;
        if (left_dec == '0) begin
          stage_nxt = SG_END_OK; phase_nxt = PH_SP_A;
        end else begin
          bit_idx_nxt = 4'd7; shift_nxt = '0; phase_nxt = PH_RB_A;
        end
      end
      PH_REQ: begin
        res.byte_request = 1'b1; phase_nxt = PH_LOAD; tick_nxt = '0;
      end
      PH_SP_A: begin
        scl_nxt = 1'b0; phase_nxt = PH_SP_B; tick_nxt = '0;
      end
      PH_SP_B: begin
        sda_nxt = 1'b0; tick_nxt = tick_inc;
        if (hold_long) begin
          phase_nxt = PH_SP_C; tick_nxt = '0;
        end
      end
      PH_SP_C: begin
        scl_nxt  = 1'b1;
        sda_nxt  = 1'b1;
        tick_nxt = tick_inc;
        if (hold_long) begin
          tick_nxt = '0;
          if (stage_r == SG_POLL_FIRST) begin
            stage_nxt = SG_POLL; poll_cnt_nxt = '0; phase_nxt = PH_ST_A;
          end else if (stage_r == SG_POLL_RETRY) begin
            phase_nxt = PH_GAP;
          end else begin
            res.done_res = 1'b1;
            res.status   = (stage_r == SG_END_NACK) ? STATUS_NACK :
                           (stage_r == SG_END_TMO)  ? STATUS_POLL_TMO : STATUS_OK;
            phase_nxt    = PH_IDLE;
          end
        end
      end
      PH_GAP: begin
        tick_nxt = tick_inc;
        if (hold_gap) begin
          stage_nxt = SG_POLL; phase_nxt = PH_ST_A; tick_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE; tick_nxt = '0;
      end
    endcase

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  // Engine state advances once per transfer taken from the input queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      stage_r    <= SG_SELW;
      op_kind_r  <= '0;
      bit_idx_r  <= '0;
      shift_r    <= '0;
      tick_r     <= '0;
      ack_cnt_r  <= '0;
      poll_cnt_r <= '0;
      addr_r     <= '0;
      left_r     <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else if (item_take) begin
      phase_r    <= phase_nxt;
      stage_r    <= stage_nxt;
      op_kind_r  <= op_kind_nxt;
      bit_idx_r  <= bit_idx_nxt;
      shift_r    <= shift_nxt;
      tick_r     <= tick_nxt;
      ack_cnt_r  <= ack_cnt_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      addr_r     <= addr_nxt;
      left_r     <= left_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_sel_r    <= RST_DEVICE_SELECT;
      addr_bytes_r <= RST_ADDR_BYTES;
      high_bits_r  <= RST_HIGH_BITS;
      long_hold_r  <= RST_LONG_HOLD;
      ack_limit_r  <= RST_ACK_WAIT_LIMIT;
      poll_gap_r   <= RST_POLL_GAP;
      poll_tries_r <= RST_POLL_TRIES;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_DEVICE_SELECT:  dev_sel_r    <= cfg.wdata[7:0];
        REG_ADDR_BYTES:     addr_bytes_r <= cfg.wdata[1:0];
        REG_HIGH_BITS:      high_bits_r  <= cfg.wdata[0];
        REG_LONG_HOLD:      long_hold_r  <= cfg.wdata[7:0];
        REG_ACK_WAIT_LIMIT: ack_limit_r  <= cfg.wdata;
        REG_POLL_GAP:       poll_gap_r   <= cfg.wdata;
        REG_POLL_TRIES:     poll_tries_r <= cfg.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/i2c_eeprom_master.sv -----
// I2C master for a serial EEPROM, driven one bus tick per input transfer.
// Input channel: push an item (command kind, sampled SDA, address, count,
// write byte) while in_full is low. Each accepted item is one timing tick;
// kind is only acted on while the block is idle.
// Result channel: while out_empty is low, out_data holds the oldest result
// (SCL/SDA levels, busy, byte request, read data, done and status); pop
// takes it. Every input item gives exactly one result, in order.
// A pushed item is registered in the input queue; the tick engine turns it
// combinationally into a result, which is registered in the result queue
// and can then be popped. The tick engine takes one item per cycle
// whenever the result queue has room.
// When the receiver stalls, the result queue fills, the engine holds its
// state, and then the input queue fills and raises in_full.
// Reset (rst_n low, synchronous) empties both queues, returns the engine to
// idle with both lines released, and loads the register reset values.
// Configuration writes take effect at the edge where cfg_we is high.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_master import iem_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire in_item_t              in_data,
  output logic                       in_full,
  input  wire logic                  out_pop,
  output out_item_t                  out_data,
  output logic                       out_empty,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  logic             q_empty, item_take, res_full, res_push;
  logic [IN_W-1:0]  q_rdata;
  in_item_t         item;
  out_item_t        res;
  logic [OUT_W-1:0] out_raw;
  cfg_wr_t          cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;
  assign item      = in_item_t'(q_rdata);
  assign out_data  = out_item_t'(out_raw);

  // Front: queue of accepted ticks.
  iem_fifo #(.WIDTH(IN_W), .DEPTH(QUEUE_DEPTH)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .wdata(IN_W'(in_data)), .full(in_full),
    .pop(item_take), .rdata(q_rdata), .empty(q_empty)
  );

  // Back: bus sequencing engine.
  iem_engine u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .item_avail(!q_empty), .item(item), .item_take(item_take),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  // Result queue toward the receiver.
  iem_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .wdata(OUT_W'(res)), .full(res_full),
    .pop(out_pop), .rdata(out_raw), .empty(out_empty)
  );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import iem_pkg::*;

  // Bus engine phases and sequence stages.
  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D, PH_WB_A, PH_WB_B, PH_WB_C,
    PH_AK_A, PH_AK_B, PH_AK_C, PH_RB_A, PH_RB_B, PH_RA_A, PH_RA_B, PH_RA_C,
    PH_REQ, PH_LOAD, PH_SP_A, PH_SP_B, PH_SP_C, PH_GAP
  } phase_e;

  typedef enum logic [3:0] {
    SG_SELW, SG_AHI, SG_ALO, SG_SELR, SG_DATA, SG_POLL, SG_POLL_FIRST,
    SG_POLL_RETRY, SG_END_OK, SG_END_NACK, SG_END_TMO
  } stage_e;

  // How the simulated EEPROM answers acknowledge slots during one command.
  typedef enum logic [2:0] {
    ANS_ACK, ANS_RANDOM, ANS_NACK_DATA, ANS_NACK_POLL
  } answer_e;

  typedef struct {
    phase_e      ph;
    stage_e      stg;
    logic [1:0]  op;
    logic [3:0]  bi;
    logic [7:0]  sb;
    logic [15:0] tc;
    logic [15:0] awc;
    logic [7:0]  pc;
    logic [15:0] ca;
    logic [15:0] bl;
    logic        scl;
    logic        sda;
  } eng_t;

  typedef struct {
    logic [7:0]  dev;
    logic [1:0]  abytes;
    logic        hb;
    logic [7:0]  hold_n;
    logic [15:0] ack_lim;
    logic [15:0] gap_n;
    logic [7:0]  tries;
  } regs_t;

  logic clk;
  logic rst_n;
  logic in_push;
  in_item_t in_data;
  logic in_full;
  logic out_pop;
  out_item_t out_data;
  logic out_empty;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2c_eeprom_master u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  regs_t regs;
  eng_t dut_eng;
  eng_t plan_eng;
  in_item_t ticks_pending[$];
  out_item_t bus_expected[$];
  int errors;
  int stall_cycles;
  int push_gap;
  int pop_gap;
  bit calm;
  bit sent;
  bit got;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor of the bus engine.
  function automatic void eng_clear(inout eng_t s);
    s.ph = PH_IDLE;
    s.stg = SG_SELW;
    s.op = '0;
    s.bi = '0;
    s.sb = '0;
    s.tc = '0;
    s.awc = '0;
    s.pc = '0;
    s.ca = '0;
    s.bl = '0;
    s.scl = 1'b1;
    s.sda = 1'b1;
  endfunction

  function automatic void go(inout eng_t s, input phase_e p);
    s.ph = p;
    s.tc = '0;
  endfunction

  function automatic bit hold_done(inout eng_t s, input logic [15:0] n);
    s.tc = s.tc + 16'd1;
    return s.tc >= n;
  endfunction

  function automatic logic [7:0] select_byte(input eng_t s, input bit rd);
    logic [7:0] v;
    v = regs.dev & 8'hFE;
    if (regs.hb) v = v | (8'(s.ca >> 7) & 8'h0E);
    if (rd) v = v | 8'h01;
    return v;
  endfunction

  function automatic void begin_byte(inout eng_t s, input logic [7:0] v);
    s.sb = v;
    s.bi = 4'd7;
    go(s, PH_WB_A);
  endfunction

  function automatic void stop_with(inout eng_t s, input stage_e sg);
    s.stg = sg;
    go(s, PH_SP_A);
  endfunction

  function automatic void write_next(inout eng_t s);
    if (s.bl == 0) begin
      stop_with(s, SG_POLL_FIRST);
    end else begin
      s.stg = SG_DATA;
      go(s, PH_REQ);
    end
  endfunction

  function automatic void on_ack(inout eng_t s);
    case (s.stg)
      SG_SELW: begin
        if (s.op == KIND_PROBE) begin
          stop_with(s, SG_END_OK);
        end else if (regs.abytes == 2'd1) begin
          s.stg = SG_ALO;
          begin_byte(s, s.ca[7:0]);
        end else begin
          s.stg = SG_AHI;
          begin_byte(s, s.ca[15:8]);
        end
      end
      SG_AHI: begin
        s.stg = SG_ALO;
        begin_byte(s, s.ca[7:0]);
      end
      SG_ALO: begin
        if (s.op == KIND_READ) begin
          s.stg = SG_SELR;
          go(s, PH_ST_A);
        end else begin
          write_next(s);
        end
      end
      SG_SELR: begin
        s.stg = SG_DATA;
        s.bi = 4'd7;
        s.sb = '0;
        go(s, PH_RB_A);
      end
      SG_DATA: begin
        if (s.bl > 0) s.bl = s.bl - 16'd1;
        s.ca = s.ca + 16'd1;
        write_next(s);
      end
      SG_POLL: stop_with(s, SG_END_OK);
      default: stop_with(s, SG_END_NACK);
    endcase
  endfunction

  function automatic void on_nack(inout eng_t s);
    if (s.stg == SG_POLL) begin
      s.pc = s.pc + 8'd1;
      stop_with(s, (s.pc >= regs.tries) ? SG_END_TMO : SG_POLL_RETRY);
    end else begin
      stop_with(s, SG_END_NACK);
    end
  endfunction

  // One tick of the engine: returns the result transfer it produces.
  function automatic out_item_t bus_tick(inout eng_t s, input in_item_t it);
    out_item_t o;
    o = '0;
    case (s.ph)
      PH_IDLE: begin
        if (it.kind == KIND_READ && it.byte_count == 0) begin
          o.done_res = 1'b1;
          o.status = STATUS_BAD_CNT;
        end else if (it.kind != KIND_TICK) begin
          s.op = it.kind;
          s.ca = it.mem_addr;
          s.bl = it.byte_count;
          s.pc = '0;
          s.stg = SG_SELW;
          go(s, PH_ST_A);
        end
      end
      PH_ST_A: begin s.sda = 1'b1; go(s, PH_ST_B); end
      PH_ST_B: begin
        s.scl = 1'b1;
        if (hold_done(s, regs.hold_n)) go(s, PH_ST_C);
      end
      PH_ST_C: begin
        s.sda = 1'b0;
        if (hold_done(s, regs.hold_n)) go(s, PH_ST_D);
      end
      PH_ST_D: begin
        s.scl = 1'b0;
        begin_byte(s, select_byte(s, s.stg == SG_SELR));
      end
      PH_WB_A: begin s.sda = s.sb[s.bi[2:0]]; go(s, PH_WB_B); end
      PH_LOAD: begin
        s.sb = it.write_byte;
        s.bi = 4'd7;
        s.sda = it.write_byte[7];
        go(s, PH_WB_B);
      end
      PH_WB_B: begin s.scl = 1'b1; go(s, PH_WB_C); end
      PH_WB_C: begin
        s.scl = 1'b0;
        if (s.bi == 0) begin
          go(s, PH_AK_A);
        end else begin
          s.bi = s.bi - 4'd1;
          go(s, PH_WB_A);
        end
      end
      PH_AK_A: begin s.sda = 1'b1; go(s, PH_AK_B); end
      PH_AK_B: begin s.scl = 1'b1; s.awc = '0; go(s, PH_AK_C); end
      PH_AK_C: begin
        if (!it.sda_in) begin
          s.scl = 1'b0;
          on_ack(s);
        end else if (s.awc >= regs.ack_lim) begin
          on_nack(s);
        end else begin
          s.awc = s.awc + 16'd1;
        end
      end
      PH_RB_A: begin s.sda = 1'b1; s.scl = 1'b1; go(s, PH_RB_B); end
      PH_RB_B: begin
        s.sb = {s.sb[6:0], it.sda_in};
        s.scl = 1'b0;
        if (s.bi == 0) begin
          o.read_byte = s.sb;
          o.read_valid = 1'b1;
          o.read_last = (s.bl <= 1);
          go(s, PH_RA_A);
        end else begin
          s.bi = s.bi - 4'd1;
          go(s, PH_RB_A);
        end
      end
      PH_RA_A: begin s.sda = (s.bl <= 1); go(s, PH_RA_B); end
      PH_RA_B: begin s.scl = 1'b1; go(s, PH_RA_C); end
      PH_RA_C: begin
        s.scl = 1'b0;
        s.sda = 1'b1;
        if (s.bl > 0) s.bl = s.bl - 16'd1;
        if (s.bl == 0) begin
          stop_with(s, SG_END_OK);
        end else begin
          s.bi = 4'd7;
          s.sb = '0;
          go(s, PH_RB_A);
        end
      end
      PH_REQ: begin o.byte_request = 1'b1; go(s, PH_LOAD); end
      PH_SP_A: begin s.scl = 1'b0; go(s, PH_SP_B); end
      PH_SP_B: begin
        s.sda = 1'b0;
        if (hold_done(s, regs.hold_n)) go(s, PH_SP_C);
      end
      PH_SP_C: begin
        s.scl = 1'b1;
        s.sda = 1'b1;
        if (hold_done(s, regs.hold_n)) begin
          if (s.stg == SG_POLL_FIRST) begin
            s.stg = SG_POLL;
            s.pc = '0;
            go(s, PH_ST_A);
          end else if (s.stg == SG_POLL_RETRY) begin
            go(s, PH_GAP);
          end else begin
            o.done_res = 1'b1;
            o.status = (s.stg == SG_END_NACK) ? STATUS_NACK :
                       (s.stg == SG_END_TMO) ? STATUS_POLL_TMO : STATUS_OK;
            go(s, PH_IDLE);
          end
        end
      end
      PH_GAP: begin
        if (hold_done(s, regs.gap_n)) begin
          s.stg = SG_POLL;
          go(s, PH_ST_A);
        end
      end
      default: go(s, PH_IDLE);
    endcase
    o.scl_out = s.scl;
    o.sda_out = s.sda;
    o.busy_res = (s.ph != PH_IDLE);
    return o;
  endfunction

  // Stimulus planning: a second copy of the engine tells what the bus expects
  // next, so the simulated EEPROM can answer acknowledge slots sensibly.
  function automatic logic pick_sda(input answer_e mode);
    bit ack_soon;
    ack_soon = (plan_eng.awc >= regs.ack_lim) || ($urandom_range(0, 3) != 0);
    if (plan_eng.ph != PH_AK_C) return 1'($urandom);
    case (mode)
      ANS_RANDOM: return ($urandom_range(0, 9) < 3);
      ANS_NACK_DATA:
        return (plan_eng.stg == SG_DATA || plan_eng.stg == SG_SELR) ? 1'b1 : !ack_soon;
      ANS_NACK_POLL: return (plan_eng.stg == SG_POLL) ? 1'b1 : !ack_soon;
      default: return !ack_soon;
    endcase
  endfunction

  function automatic void plan_push(input in_item_t it);
    out_item_t unused;
    unused = bus_tick(plan_eng, it);
    ticks_pending.push_back(it);
  endfunction

  function automatic in_item_t noise_tick(input answer_e mode);
    in_item_t it;
    it.mem_addr = 16'($urandom);
    it.byte_count = 16'($urandom);
    it.write_byte = 8'($urandom);
    it.sda_in = pick_sda(mode);
    // Commands that arrive while busy must be ignored.
    it.kind = ($urandom_range(0, 9) == 0 && plan_eng.ph != PH_IDLE) ?
              2'($urandom) : KIND_TICK;
    return it;
  endfunction

  // One command followed by ticks until the engine is idle again.
  function automatic void issue(input logic [1:0] k, input logic [15:0] addr,
                                input logic [15:0] cnt, input answer_e mode);
    in_item_t it;
    it = noise_tick(mode);
    it.kind = k;
    it.mem_addr = addr;
    it.byte_count = cnt;
    plan_push(it);
    while (plan_eng.ph != PH_IDLE) plan_push(noise_tick(mode));
    repeat ($urandom_range(0, 3)) begin
      it = noise_tick(ANS_ACK);
      it.kind = KIND_TICK;
      plan_push(it);
    end
  endfunction

  function automatic void random_commands(input int n);
    logic [1:0] k;
    logic [15:0] cnt;
    answer_e mode;
    int r;
    for (int i = 0; i < n; i++) begin
      k = 2'($urandom_range(1, 3));
      if (k == KIND_READ)
        cnt = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      else if (k == KIND_WRITE)
        cnt = 16'($urandom_range(0, 5));
      else
        cnt = 16'($urandom);
      r = $urandom_range(0, 99);
      if (regs.ack_lim > 64 || r < 55) mode = ANS_ACK;
      else if (r < 80) mode = ANS_RANDOM;
      else if (r < 92) mode = ANS_NACK_DATA;
      else mode = ANS_NACK_POLL;
      issue(k, 16'($urandom), cnt, mode);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void check_result(input out_item_t act);
    out_item_t exp_r;
    if (bus_expected.size() == 0) begin
      $display("%0t ns: unexpected result transfer %h, expected none", $time, act);
      errors++;
      return;
    end
    exp_r = bus_expected.pop_front();
    check_field("scl_out", exp_r.scl_out, act.scl_out);
    check_field("sda_out", exp_r.sda_out, act.sda_out);
    check_field("busy_res", exp_r.busy_res, act.busy_res);
    check_field("byte_request", exp_r.byte_request, act.byte_request);
    check_field("read_byte", exp_r.read_byte, act.read_byte);
    check_field("read_valid", exp_r.read_valid, act.read_valid);
    check_field("read_last", exp_r.read_last, act.read_last);
    check_field("done_res", exp_r.done_res, act.done_res);
    check_field("status", exp_r.status, act.status);
  endfunction

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      sent = in_push && !in_full;
      got = out_pop && !out_empty;
      if (sent) bus_expected.push_back(bus_tick(dut_eng, in_data));
      if (got) check_result(out_data);
      stall_cycles = (sent || got) ? 0 : stall_cycles + 1;
      if (stall_cycles >= 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Input driver: one transfer per item from the pending queue.
  always @(negedge clk) begin
    if (rst_n && (!in_push || sent)) begin
      if (push_gap > 0) begin
        in_push <= 1'b0;
        push_gap--;
      end else if (ticks_pending.size() > 0) begin
        in_push <= 1'b1;
        in_data <= ticks_pending.pop_front();
        push_gap = pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Result side: pop with random stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
        if (got) pop_gap = pick_gap();
      end
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_DEVICE_SELECT:  regs.dev = v[7:0];
      REG_ADDR_BYTES:     regs.abytes = v[1:0];
      REG_HIGH_BITS:      regs.hb = v[0];
      REG_LONG_HOLD:      regs.hold_n = v[7:0];
      REG_ACK_WAIT_LIMIT: regs.ack_lim = v;
      REG_POLL_GAP:       regs.gap_n = v;
      REG_POLL_TRIES:     regs.tries = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [7:0] dev, input logic [1:0] ab, input logic hb,
                         input logic [7:0] hold_n, input logic [15:0] ack_lim,
                         input logic [15:0] gap_n, input logic [7:0] tries);
    set_reg(REG_DEVICE_SELECT, {8'd0, dev});
    set_reg(REG_ADDR_BYTES, {14'd0, ab});
    set_reg(REG_HIGH_BITS, {15'd0, hb});
    set_reg(REG_LONG_HOLD, {8'd0, hold_n});
    set_reg(REG_ACK_WAIT_LIMIT, ack_lim);
    set_reg(REG_POLL_GAP, gap_n);
    set_reg(REG_POLL_TRIES, {8'd0, tries});
  endtask

  // Wait until every planned tick has been sent and every result checked.
  task automatic drain();
    while (ticks_pending.size() != 0 || in_push || bus_expected.size() != 0)
      @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors = 0;
    stall_cycles = 0;
    push_gap = 0;
    pop_gap = 0;
    calm = 1'b0;
    sent = 1'b0;
    got = 1'b0;
    regs.dev = RST_DEVICE_SELECT;
    regs.abytes = RST_ADDR_BYTES;
    regs.hb = RST_HIGH_BITS;
    regs.hold_n = RST_LONG_HOLD;
    regs.ack_lim = RST_ACK_WAIT_LIMIT;
    regs.gap_n = RST_POLL_GAP;
    regs.tries = RST_POLL_TRIES;
    eng_clear(dut_eng);
    eng_clear(plan_eng);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset register values.
    issue(KIND_WRITE, 16'h0042, 16'd2, ANS_ACK);
    issue(KIND_READ, 16'h0042, 16'd2, ANS_ACK);
    issue(KIND_PROBE, 16'h0000, 16'd0, ANS_ACK);
    drain();

    // Directed cases: address wrap, refused read, huge counts cut short by
    // a NACK, empty write, probe with high bits, select NACK, poll timeout.
    set_all(8'd0, 2'd2, 1'b1, 8'd1, 16'd1, 16'd1, 8'd1);
    issue(KIND_WRITE, 16'hFFFF, 16'd2, ANS_ACK);
    issue(KIND_READ, 16'h0755, 16'd0, ANS_ACK);
    issue(KIND_READ, 16'h0700, 16'hFFFF, ANS_NACK_DATA);
    issue(KIND_WRITE, 16'h0000, 16'hFFFF, ANS_NACK_DATA);
    issue(KIND_WRITE, 16'h1234, 16'd0, ANS_ACK);
    issue(KIND_PROBE, 16'h0500, 16'hFFFF, ANS_ACK);
    issue(KIND_PROBE, 16'h0000, 16'h0000, ANS_RANDOM);
    issue(KIND_WRITE, 16'h0300, 16'd1, ANS_NACK_POLL);
    issue(KIND_READ, 16'h00FF, 16'd1, ANS_ACK);
    issue(KIND_READ, 16'h0300, 16'd3, ANS_ACK);
    random_commands(1);
    drain();

    // Calm stretch: pushes and pops follow with no random gaps.
    calm = 1'b1;
    set_all(8'd254, 2'd1, 1'b0, 8'd2, 16'd3, 16'd5, 8'd3);
    random_commands(3);
    drain();
    calm = 1'b0;

    // Long start and stop holds.
    set_all(8'd254, 2'd2, 1'b1, 8'd40, 16'd8, 16'd2, 8'd255);
    random_commands(1);
    drain();

    // Longest acknowledge wait.
    set_all(8'($urandom_range(0, 254)), 2'd2, 1'b0, 8'd1, 16'hFFFF, 16'd3, 8'd2);
    random_commands(1);
    drain();

    // Long poll gap with one retry before timeout.
    set_all(8'hA0, 2'd1, 1'b1, 8'd1, 16'd2, 16'd60, 8'd2);
    issue(KIND_WRITE, 16'h0123, 16'd1, ANS_NACK_POLL);
    drain();

    // Zero hold, poll gap and poll try registers act as one; address byte counts outside 1 send two.
    set_all(8'($urandom_range(0, 254)), 2'd0, 1'b1, 8'd0, 16'd0, 16'd0, 8'd0);
    random_commands(2);
    drain();
    set_reg(REG_ADDR_BYTES, 16'd3);
    random_commands(1);
    drain();

    // Random settings.
    set_all(8'($urandom_range(0, 254)), 2'($urandom_range(1, 2)), 1'($urandom),
            8'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
            16'($urandom_range(1, 20)), 8'($urandom_range(1, 4)));
    random_commands(3);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
